### rtl/att_pkg.sv
// Package for the allocation tracking table.
// Holds field widths, the event and state codes, and the structs shared by the modules.
// Depends on nothing.
package att_pkg;

  localparam int TableEntriesDflt = 256;
  localparam int FuncW = 2;
  localparam int AddrW = 48;
  localparam int ReqW = 24;
  localparam int SumW = 48;
  localparam int LiveW = 9;

  typedef enum logic [FuncW-1:0] {
    FUNC_ALLOC   = 2'd0,
    FUNC_ARRAY   = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_REALLOC = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_SCAN,
    ST_MOVE,
    ST_INS,
    ST_OUT
  } state_t;

  typedef enum logic {
    ALU_FREE,
    ALU_ALLOC
  } alu_op_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  typedef struct packed {
    logic             found;
    logic             overflow;
    logic [LiveW-1:0] live_entries;
    logic [SumW-1:0]  total_allocated_bytes;
    logic [SumW-1:0]  total_freed_bytes;
  } res_t;

endpackage

### rtl/att_in_if.sv
// Input channel of the allocation tracking table: one event word per handshake.
// Depends on att_pkg.
interface att_in_if;
  logic                       valid;
  logic                       ready;
  logic [att_pkg::FuncW-1:0]  func;
  logic [att_pkg::AddrW-1:0]  new_address;
  logic [att_pkg::AddrW-1:0]  old_address;
  logic [att_pkg::ReqW-1:0]   byte_size;
  logic [att_pkg::ReqW-1:0]   element_count;

  modport source (output valid, func, new_address, old_address, byte_size, element_count,
                  input ready);
  modport sink (input valid, func, new_address, old_address, byte_size, element_count,
                output ready);
endinterface

### rtl/att_out_if.sv
// Result channel of the allocation tracking table: one status word per event.
// Depends on att_pkg.
interface att_out_if;
  logic                       valid;
  logic                       ready;
  logic                       found;
  logic                       overflow;
  logic [att_pkg::LiveW-1:0]  live_entries;
  logic [att_pkg::SumW-1:0]   total_allocated_bytes;
  logic [att_pkg::SumW-1:0]   total_freed_bytes;

  modport source (output valid, found, overflow, live_entries, total_allocated_bytes,
                  total_freed_bytes, input ready);
  modport sink (input valid, found, overflow, live_entries, total_allocated_bytes,
                total_freed_bytes, output ready);
endinterface

### rtl/att_cfg_if.sv
// Configuration write channel of the allocation tracking table.
// Carries the logging enable bit; depends on nothing.
interface att_cfg_if;
  logic valid;
  logic ready;
  logic logging_enable;

  modport source (output valid, logging_enable, input ready);
  modport sink (input valid, logging_enable, output ready);
endinterface

### rtl/att_mem.sv
// Entry memory of the allocation tracking table: one write and one registered read port.
// Depends on att_pkg.
module att_mem #(
  parameter int ENTRIES = att_pkg::TableEntriesDflt,
  parameter int WIDTH   = 2 * att_pkg::AddrW
) (
  input  logic                       clk,
  input  att_pkg::mem_ctl_t          ctl,
  input  logic [$clog2(ENTRIES)-1:0] wr_addr,
  input  logic [WIDTH-1:0]           wr_data,
  input  logic [$clog2(ENTRIES)-1:0] rd_addr,
  output logic [WIDTH-1:0]           rd_data
);

  logic [WIDTH-1:0] mem [ENTRIES];

  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/att_alu.sv
// Shared 48-bit adder and address comparator of the allocation tracking table.
// Depends on att_pkg.
module att_alu (
  input  att_pkg::alu_op_t            op,
  input  logic [att_pkg::SumW-1:0]    alloc_sum,
  input  logic [att_pkg::SumW-1:0]    freed_sum,
  input  logic [att_pkg::SumW-1:0]    entry_size,
  input  logic [att_pkg::SumW-1:0]    item_size,
  input  logic [att_pkg::AddrW-1:0]   entry_addr,
  input  logic [att_pkg::AddrW-1:0]   key_addr,
  output logic [att_pkg::SumW-1:0]    sum,
  output logic                        match
);

  logic [att_pkg::SumW-1:0] opa;
  logic [att_pkg::SumW-1:0] opb;

  always_comb begin
    unique case (op)
      att_pkg::ALU_FREE: begin
        opa = freed_sum;
        opb = entry_size;
      end
      att_pkg::ALU_ALLOC: begin
        opa = alloc_sum;
        opb = item_size;
      end
      default: begin
        opa = alloc_sum;
        opb = item_size;
      end
    endcase
  end

  assign sum   = opa + opb;
  assign match = (entry_addr == key_addr);

endmodule

### rtl/att_ctrl.sv
// Sequencer of the allocation tracking table: scans, fills holes, inserts, keeps totals.
// Depends on att_pkg, att_in_if, att_mem and att_alu.
module att_ctrl #(
  parameter int TABLE_ENTRIES = att_pkg::TableEntriesDflt
) (
  input  logic         clk,
  input  logic         rst_n,
  att_in_if.sink       in_ch,
  input  logic         enable,
  input  logic         out_free,
  output logic         res_load,
  output att_pkg::res_t res
);

  localparam int IdxW = $clog2(TABLE_ENTRIES);
  localparam int CntW = $clog2(TABLE_ENTRIES + 1);
  localparam int AW   = att_pkg::AddrW;
  localparam int SW   = att_pkg::SumW;
  localparam int RW   = att_pkg::ReqW;

  att_pkg::state_t state_r, state_nxt;
  logic [CntW-1:0] count_r, count_nxt;
  logic [SW-1:0]   alloc_r, alloc_nxt;
  logic [SW-1:0]   freed_r, freed_nxt;
  logic            ovf_r, ovf_nxt;

  att_pkg::func_t  func_r, func_nxt;
  logic [AW-1:0]   new_r, new_nxt;
  logic [AW-1:0]   old_r, old_nxt;
  logic [RW-1:0]   bsize_r, bsize_nxt;
  logic [RW-1:0]   ecount_r, ecount_nxt;
  logic [SW-1:0]   size_r, size_nxt;
  logic            do_rel_r, do_rel_nxt;
  logic            do_ins_r, do_ins_nxt;
  logic            found_r, found_nxt;
  logic [CntW-1:0] scan_r, scan_nxt;
  logic            cmp_v_r, cmp_v_nxt;
  logic [IdxW-1:0] cmp_idx_r, cmp_idx_nxt;
  logic [IdxW-1:0] hole_r, hole_nxt;

  att_pkg::func_t    in_func;
  logic              plan_rel;
  logic              plan_ins;
  logic [SW-1:0]     prod;
  logic [CntW-1:0]   last;
  att_pkg::mem_ctl_t mem_ctl;
  logic [IdxW-1:0]   wr_addr;
  logic [IdxW-1:0]   rd_addr;
  logic [2*AW-1:0]   rd_data;
  att_pkg::alu_op_t  alu_op;
  logic [SW-1:0]     alu_sum;
  logic              alu_match;

  assign in_func = att_pkg::func_t'(in_ch.func);
  assign prod    = SW'(ecount_r) * SW'(bsize_r);
  assign last    = count_r - CntW'(1);

  always_comb begin
    plan_rel = 1'b0;
    plan_ins = 1'b0;
    unique case (in_func)
      att_pkg::FUNC_ALLOC, att_pkg::FUNC_ARRAY: begin
        plan_ins = (in_ch.new_address != '0);
      end
      att_pkg::FUNC_RELEASE: begin
        plan_rel = 1'b1;
      end
      att_pkg::FUNC_REALLOC: begin
        if (in_ch.new_address != '0) begin
          plan_rel = (in_ch.old_address != '0);
          plan_ins = (in_ch.old_address == '0) || (in_ch.byte_size != '0);
        end
      end
      default: begin
        plan_rel = 1'b0;
      end
    endcase
    plan_rel = plan_rel && enable;
    plan_ins = plan_ins && enable;
  end

  att_mem #(
    .ENTRIES (TABLE_ENTRIES),
    .WIDTH   (2 * AW)
  ) u_mem (
    .clk     (clk),
    .ctl     (mem_ctl),
    .wr_addr (wr_addr),
    .wr_data ((state_r == att_pkg::ST_MOVE) ? rd_data : {new_r, size_r}),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  att_alu u_alu (
    .op         (alu_op),
    .alloc_sum  (alloc_r),
    .freed_sum  (freed_r),
    .entry_size (rd_data[SW-1:0]),
    .item_size  (size_r),
    .entry_addr (rd_data[2*AW-1:AW]),
    .key_addr   (old_r),
    .sum        (alu_sum),
    .match      (alu_match)
  );

  always_comb begin
    state_nxt   = state_r;
    count_nxt   = count_r;
    alloc_nxt   = alloc_r;
    freed_nxt   = freed_r;
    ovf_nxt     = ovf_r;
    func_nxt    = func_r;
    new_nxt     = new_r;
    old_nxt     = old_r;
    bsize_nxt   = bsize_r;
    ecount_nxt  = ecount_r;
    size_nxt    = size_r;
    do_rel_nxt  = do_rel_r;
    do_ins_nxt  = do_ins_r;
    found_nxt   = found_r;
    scan_nxt    = scan_r;
    cmp_v_nxt   = cmp_v_r;
    cmp_idx_nxt = cmp_idx_r;
    hole_nxt    = hole_r;
    mem_ctl     = '0;
    wr_addr     = count_r[IdxW-1:0];
    rd_addr     = scan_r[IdxW-1:0];
    alu_op      = att_pkg::ALU_ALLOC;
    in_ch.ready = 1'b0;
    res_load    = 1'b0;

    unique case (state_r)
      att_pkg::ST_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          func_nxt   = in_func;
          new_nxt    = in_ch.new_address;
          old_nxt    = in_ch.old_address;
          bsize_nxt  = in_ch.byte_size;
          ecount_nxt = in_ch.element_count;
          do_rel_nxt = plan_rel;
          do_ins_nxt = plan_ins;
          found_nxt  = 1'b0;
          scan_nxt   = '0;
          cmp_v_nxt  = 1'b0;
          state_nxt  = att_pkg::ST_MUL;
        end
      end
      att_pkg::ST_MUL: begin
        size_nxt = (func_r == att_pkg::FUNC_ARRAY) ? prod : SW'(bsize_r);
        if (do_rel_r) begin
          state_nxt = att_pkg::ST_SCAN;
        end else if (do_ins_r) begin
          state_nxt = att_pkg::ST_INS;
        end else begin
          state_nxt = att_pkg::ST_OUT;
        end
      end
      att_pkg::ST_SCAN: begin
        alu_op = att_pkg::ALU_FREE;
        if (cmp_v_r && alu_match) begin
          freed_nxt     = alu_sum;
          hole_nxt      = cmp_idx_r;
          rd_addr       = last[IdxW-1:0];
          mem_ctl.rd_en = 1'b1;
          state_nxt     = att_pkg::ST_MOVE;
        end else if (scan_r < count_r) begin
          mem_ctl.rd_en = 1'b1;
          cmp_idx_nxt   = scan_r[IdxW-1:0];
          cmp_v_nxt     = 1'b1;
          scan_nxt      = scan_r + CntW'(1);
        end else begin
          cmp_v_nxt = 1'b0;
          if (!cmp_v_r) begin
            state_nxt = do_ins_r ? att_pkg::ST_INS : att_pkg::ST_OUT;
          end
        end
      end
      att_pkg::ST_MOVE: begin
        mem_ctl.wr_en = 1'b1;
        wr_addr       = hole_r;
        count_nxt     = last;
        found_nxt     = 1'b1;
        state_nxt     = do_ins_r ? att_pkg::ST_INS : att_pkg::ST_OUT;
      end
      att_pkg::ST_INS: begin
        alloc_nxt = alu_sum;
        if (count_r < CntW'(TABLE_ENTRIES)) begin
          mem_ctl.wr_en = 1'b1;
          count_nxt     = count_r + CntW'(1);
        end else begin
          ovf_nxt = 1'b1;
        end
        state_nxt = att_pkg::ST_OUT;
      end
      att_pkg::ST_OUT: begin
        if (out_free) begin
          res_load  = 1'b1;
          state_nxt = att_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = att_pkg::ST_IDLE;
      end
    endcase
  end

  assign res.found                 = found_r;
  assign res.overflow              = ovf_r;
  assign res.live_entries          = att_pkg::LiveW'(count_r);
  assign res.total_allocated_bytes = alloc_r;
  assign res.total_freed_bytes     = freed_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= att_pkg::ST_IDLE;
      count_r <= '0;
      alloc_r <= '0;
      freed_r <= '0;
      ovf_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      alloc_r <= alloc_nxt;
      freed_r <= freed_nxt;
      ovf_r   <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    func_r    <= func_nxt;
    new_r     <= new_nxt;
    old_r     <= old_nxt;
    bsize_r   <= bsize_nxt;
    ecount_r  <= ecount_nxt;
    size_r    <= size_nxt;
    do_rel_r  <= do_rel_nxt;
    do_ins_r  <= do_ins_nxt;
    found_r   <= found_nxt;
    scan_r    <= scan_nxt;
    cmp_v_r   <= cmp_v_nxt;
    cmp_idx_r <= cmp_idx_nxt;
    hole_r    <= hole_nxt;
  end

endmodule

### rtl/allocation_tracking_table.sv
// Top level of the allocation tracking table: enable register, result register, sequencer.
// Depends on att_pkg, att_in_if, att_out_if, att_cfg_if and att_ctrl.
//
//   channel  direction  word
//   in_ch    sink       func, new_address, old_address, byte_size, element_count
//   out_ch   source     found, overflow, live_entries, total_allocated_bytes, total_freed_bytes
//   cfg_ch   sink       logging_enable
//
// An event passes through IDLE, MUL and OUT, with INS when it inserts; a release adds SCAN
// and, on a match, MOVE before INS or OUT.
// The linear search reads one entry per cycle from the single-read-port entry memory.
// Reset clears the count, the totals and the overflow flag; the entry memory is not cleared.
// A stalled result waits in the output register while the next word is taken in.
module allocation_tracking_table #(
  parameter int TABLE_ENTRIES = att_pkg::TableEntriesDflt
) (
  input  logic     clk,
  input  logic     rst_n,
  att_in_if.sink   in_ch,
  att_out_if.source out_ch,
  att_cfg_if.sink  cfg_ch
);

  logic          enable_r;
  logic          out_valid_r;
  att_pkg::res_t out_r;
  logic          out_free;
  logic          res_load;
  att_pkg::res_t res;

  assign cfg_ch.ready = 1'b1;
  assign out_free     = !out_valid_r || out_ch.ready;

  att_ctrl #(
    .TABLE_ENTRIES (TABLE_ENTRIES)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .enable   (enable_r),
    .out_free (out_free),
    .res_load (res_load),
    .res      (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_ch.valid) begin
        enable_r <= cfg_ch.logging_enable;
      end
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_r <= res;
    end
  end

  assign out_ch.valid                 = out_valid_r;
  assign out_ch.found                 = out_r.found;
  assign out_ch.overflow              = out_r.overflow;
  assign out_ch.live_entries          = out_r.live_entries;
  assign out_ch.total_allocated_bytes = out_r.total_allocated_bytes;
  assign out_ch.total_freed_bytes     = out_r.total_freed_bytes;

`ifndef SYNTHESIS
  a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (!out_valid_r || out_ch.ready))
    else $error("result loaded over an untaken result");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("new word taken while an event is in progress");

  a_live_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    res_load |-> (32'(res.live_entries) <= TABLE_ENTRIES))
    else $error("live entry count beyond table depth");

  a_overflow_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    res.overflow |=> res.overflow)
    else $error("overflow flag cleared");
`endif

endmodule

### test/tb_allocation_tracking_table.sv
// Self-checking testbench for allocation_tracking_table: directed and random event words,
// with every result word compared against a behavioral copy of the table and totals.
// Depends on att_pkg, att_in_if, att_out_if, att_cfg_if and the RTL of the block.
module tb_allocation_tracking_table;

  localparam int Depth = att_pkg::TableEntriesDflt;
  localparam int QuietLimit = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  att_in_if  in_ch ();
  att_out_if out_ch ();
  att_cfg_if cfg_ch ();

  allocation_tracking_table #(.TABLE_ENTRIES(Depth)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  always #2 clk = ~clk;

  logic [att_pkg::AddrW-1:0] table_addr [Depth];
  logic [att_pkg::SumW-1:0]  table_size [Depth];
  int                        live_count = 0;
  logic [att_pkg::SumW-1:0]  alloc_sum = '0;
  logic [att_pkg::SumW-1:0]  free_sum = '0;
  bit                        overflow_flag = 1'b0;
  bit                        logging_on = 1'b0;

  att_pkg::res_t expected_status [$];
  att_pkg::res_t want;
  int   error_cnt = 0;
  int   events_sent = 0;
  int   results_seen = 0;
  int   hits_seen = 0;
  int   quiet_cycles = 0;
  int   stall_left = 0;
  bit   no_idle = 1'b0;

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (no_idle || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic void add_entry(logic [att_pkg::AddrW-1:0] a,
                                    logic [att_pkg::SumW-1:0] s);
    if (live_count < Depth) begin
      table_addr[live_count] = a;
      table_size[live_count] = s;
      live_count++;
    end else begin
      overflow_flag = 1'b1;
    end
    alloc_sum = alloc_sum + s;
  endfunction

  function automatic bit drop_entry(logic [att_pkg::AddrW-1:0] a);
    for (int i = 0; i < live_count; i++) begin
      if (table_addr[i] == a) begin
        free_sum = free_sum + table_size[i];
        table_addr[i] = table_addr[live_count-1];
        table_size[i] = table_size[live_count-1];
        live_count--;
        return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void apply_event(att_pkg::func_t f, logic [att_pkg::AddrW-1:0] na,
                                      logic [att_pkg::AddrW-1:0] oa,
                                      logic [att_pkg::ReqW-1:0] bs,
                                      logic [att_pkg::ReqW-1:0] ec);
    att_pkg::res_t r;
    bit   hit;
    hit = 1'b0;
    if (logging_on) begin
      case (f)
        att_pkg::FUNC_ALLOC: begin
          if (na != '0) add_entry(na, {24'd0, bs});
        end
        att_pkg::FUNC_ARRAY: begin
          if (na != '0) add_entry(na, {24'd0, ec} * {24'd0, bs});
        end
        att_pkg::FUNC_RELEASE: begin
          hit = drop_entry(oa);
        end
        default: begin
          if (na != '0) begin
            if (oa == '0) begin
              add_entry(na, {24'd0, bs});
            end else begin
              hit = drop_entry(oa);
              if (bs != '0) add_entry(na, {24'd0, bs});
            end
          end
        end
      endcase
    end
    r.found = hit;
    r.overflow = overflow_flag;
    r.live_entries = att_pkg::LiveW'(live_count);
    r.total_allocated_bytes = alloc_sum;
    r.total_freed_bytes = free_sum;
    expected_status.push_back(r);
  endfunction

  function automatic void check_field(string name, logic [att_pkg::SumW-1:0] exp_v,
                                      logic [att_pkg::SumW-1:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      error_cnt++;
    end
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      results_seen++;
      if (out_ch.found === 1'b1) hits_seen++;
      if (expected_status.size() == 0) begin
        $error("result word arrived with no event waiting for it");
        error_cnt++;
      end else begin
        want = expected_status.pop_front();
        check_field("found", want.found, out_ch.found);
        check_field("overflow", want.overflow, out_ch.overflow);
        check_field("live_entries", want.live_entries, out_ch.live_entries);
        check_field("total_allocated_bytes", want.total_allocated_bytes,
                    out_ch.total_allocated_bytes);
        check_field("total_freed_bytes", want.total_freed_bytes, out_ch.total_freed_bytes);
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_ch.ready = 1'b0;
      stall_left--;
    end else begin
      out_ch.ready = 1'b1;
      if (!no_idle && $urandom_range(3) == 0) stall_left = pick_gap();
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        quiet_cycles = 0;
      end else if (quiet_cycles >= QuietLimit) begin
        $display("Timeout: no word moved for %0d cycles.", QuietLimit);
        $display("CHECK FAILED");
        $finish;
      end else begin
        quiet_cycles++;
      end
    end
  end

  task automatic send_event(input att_pkg::func_t f, input logic [att_pkg::AddrW-1:0] na,
                            input logic [att_pkg::AddrW-1:0] oa,
                            input logic [att_pkg::ReqW-1:0] bs,
                            input logic [att_pkg::ReqW-1:0] ec);
    int gap;
    gap = pick_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.func = f;
    in_ch.new_address = na;
    in_ch.old_address = oa;
    in_ch.byte_size = bs;
    in_ch.element_count = ec;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    apply_event(f, na, oa, bs, ec);
    events_sent++;
  endtask

  task automatic drain();
    @(negedge clk);
    in_ch.valid = 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_logging(input bit en);
    drain();
    @(negedge clk);
    cfg_ch.logging_enable = en;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    logging_on = en;
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [att_pkg::AddrW-1:0] rand_addr();
    logic [att_pkg::AddrW-1:0] a;
    if ($urandom_range(9) == 0) a = att_pkg::AddrW'($urandom_range(1, 255));
    else a = {16'($urandom()), $urandom()};
    if (a == '0) a = 48'd1;
    return a;
  endfunction

  function automatic logic [att_pkg::AddrW-1:0] rand_new();
    if ($urandom_range(99) < 6) return '0;
    return rand_addr();
  endfunction

  function automatic logic [att_pkg::AddrW-1:0] rand_old();
    int r;
    r = $urandom_range(99);
    if (r < 10) return '0;
    if (r < 75 && live_count > 0) return table_addr[$urandom_range(live_count - 1)];
    return rand_addr();
  endfunction

  function automatic logic [att_pkg::ReqW-1:0] rand_req();
    int r;
    r = $urandom_range(99);
    if (r < 8) return '0;
    if (r < 16) return '1;
    if (r < 60) return att_pkg::ReqW'($urandom_range(1, 4096));
    return att_pkg::ReqW'($urandom());
  endfunction

  task automatic send_random(input int release_pct);
    att_pkg::func_t f;
    int    r;
    r = $urandom_range(99);
    if (r < release_pct) f = att_pkg::FUNC_RELEASE;
    else f = att_pkg::func_t'($urandom_range(2) == 2 ? att_pkg::FUNC_REALLOC :
                                                       $urandom_range(1));
    send_event(f, rand_new(), rand_old(), rand_req(), rand_req());
  endtask

  task automatic test_disabled_after_reset();
    send_event(att_pkg::FUNC_ALLOC, 48'h1234, '0, 24'd10, '0);
    send_event(att_pkg::FUNC_ARRAY, 48'h5678, '0, 24'd4, 24'd3);
    send_event(att_pkg::FUNC_RELEASE, '0, 48'h1234, '0, '0);
    send_event(att_pkg::FUNC_REALLOC, 48'h9abc, 48'h5678, 24'd8, '0);
  endtask

  task automatic test_directed_events();
    write_logging(1'b1);
    send_event(att_pkg::FUNC_ALLOC, '1, '0, '1, '0);
    send_event(att_pkg::FUNC_ALLOC, 48'h1, '0, '0, '1);
    send_event(att_pkg::FUNC_ALLOC, '0, '0, 24'd5, '0);
    send_event(att_pkg::FUNC_ARRAY, 48'h0000_1000_0000, '0, '1, '1);
    send_event(att_pkg::FUNC_ARRAY, 48'h0000_2000_0000, '0, 24'd77, '0);
    send_event(att_pkg::FUNC_ARRAY, 48'h0000_3000_0000, '0, '1, '1);
    send_event(att_pkg::FUNC_RELEASE, '0, 48'h1, '0, '0);
    send_event(att_pkg::FUNC_RELEASE, '0, 48'h5555_5555_5555, '0, '0);
    send_event(att_pkg::FUNC_RELEASE, 48'h42, '0, '0, '0);
    send_event(att_pkg::FUNC_REALLOC, '0, 48'h0000_1000_0000, 24'd9, '0);
    send_event(att_pkg::FUNC_REALLOC, 48'h0000_4000_0000, '0, 24'd100, '0);
    send_event(att_pkg::FUNC_REALLOC, 48'h0000_5000_0000, 48'h0000_1000_0000, '0, '0);
    send_event(att_pkg::FUNC_REALLOC, 48'h0000_6000_0000, 48'h0000_3000_0000, '1, '0);
    send_event(att_pkg::FUNC_REALLOC, 48'h0000_7000_0000, 48'haaaa_aaaa_aaaa, 24'd1, '0);
    send_event(att_pkg::FUNC_RELEASE, '0, '1, '0, '0);
    send_event(att_pkg::FUNC_ARRAY, '1, '0, 24'd1, 24'd1);
  endtask

  task automatic test_random_mix();
    repeat (300) send_random(30);
    drain();
  endtask

  task automatic test_table_full();
    while (live_count < Depth) begin
      send_event(att_pkg::func_t'($urandom_range(1) ? att_pkg::FUNC_ALLOC :
                                                      att_pkg::FUNC_ARRAY),
                 rand_addr(), '0, rand_req(), rand_req());
    end
    repeat (30) begin
      send_event(att_pkg::func_t'($urandom_range(1) ? att_pkg::FUNC_REALLOC :
                                                      att_pkg::FUNC_ALLOC),
                 rand_addr(), rand_old(), rand_req(), rand_req());
    end
    repeat (40) begin
      send_event(att_pkg::FUNC_RELEASE, rand_addr(), rand_old(), rand_req(), rand_req());
    end
    repeat (60) send_random(15);
    drain();
  endtask

  task automatic test_logging_toggle();
    write_logging(1'b0);
    repeat (40) send_random(30);
    write_logging(1'b1);
    no_idle = 1'b1;
    repeat (100) send_random(40);
    no_idle = 1'b0;
    repeat (100) send_random(40);
    drain();
  endtask

  initial begin
    in_ch.valid = 1'b0;
    in_ch.func = att_pkg::FUNC_ALLOC;
    in_ch.new_address = '0;
    in_ch.old_address = '0;
    in_ch.byte_size = '0;
    in_ch.element_count = '0;
    out_ch.ready = 1'b1;
    cfg_ch.valid = 1'b0;
    cfg_ch.logging_enable = 1'b0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(posedge clk);

    test_disabled_after_reset();
    test_directed_events();
    test_random_mix();
    test_table_full();
    test_logging_toggle();

    drain();
    repeat (300) @(posedge clk);
    if (expected_status.size() != 0) begin
      $error("%0d expected result words never arrived", expected_status.size());
      error_cnt++;
    end
    $display("Sent %0d events over both logging settings, %0d results checked.",
             events_sent, results_seen);
    $display("Releases that hit: %0d; table filled to overflow: %0d.", hits_seen,
             overflow_flag);
    if (error_cnt == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

### files.f
rtl/att_pkg.sv
rtl/att_in_if.sv
rtl/att_out_if.sv
rtl/att_cfg_if.sv
rtl/att_mem.sv
rtl/att_alu.sv
rtl/att_ctrl.sv
rtl/allocation_tracking_table.sv
test/tb_allocation_tracking_table.sv
